// ----- src/cto_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cto_pkg: shared definitions for the connection timeout table
// Sizes, request opcodes, result kinds and the cell entry and command types.
// ---------------------------------------------------------------------------
package cto_pkg;

  // table geometry
  localparam int SLOTS     = 64;
  localparam int TIME_BITS = 32;
  localparam int SOCK_BITS = 6;
  localparam int SOCKETS   = 1 << SOCK_BITS;

  // port field widths
  localparam int OP_BITS    = 2;
  localparam int FIELD_TIME = 32;

  // request opcodes
  localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_TICK   = 2'd2;

  // result kinds
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_DROPPED = 1'b1;

  // one table cell
  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] tstamp;
    logic [SOCK_BITS-1:0] sock;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic                 pop;
    logic [TIME_BITS-1:0] key_time;
    logic [SOCK_BITS-1:0] key_sock;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- src/cto_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cto_ifs: request and result channels
// Valid/ready channels for incoming requests and outgoing results.
// ---------------------------------------------------------------------------
interface cto_req_if;
  logic                           valid;
  logic                           ready;
  logic [cto_pkg::OP_BITS-1:0]    op;
  logic [cto_pkg::SOCK_BITS-1:0]  socket_id;
  logic [cto_pkg::FIELD_TIME-1:0] expiry;
  logic [cto_pkg::FIELD_TIME-1:0] now_time;

  modport source (output valid, op, socket_id, expiry, now_time, input ready);
  modport sink   (input valid, op, socket_id, expiry, now_time, output ready);
endinterface

interface cto_res_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [cto_pkg::SOCK_BITS-1:0] out_socket;
  logic                          last;

  modport source (output valid, kind, out_socket, last, input ready);
  modport sink   (input valid, kind, out_socket, last, output ready);
endinterface

`default_nettype wire

// ----- src/cto_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cto_cell: one slot of the sorted timeout chain
// Holds one (expiry, socket) entry; shifts up on insert, down on removal.
// ---------------------------------------------------------------------------
module cto_cell (
  input  wire                     logic clk,
  input  wire                     logic rst,
  input  wire cto_pkg::cell_cmd_t cmd,
  input  wire cto_pkg::entry_t    below,
  input  wire                     logic below_keep,
  input  wire cto_pkg::entry_t    above,
  input  wire                     logic del_in,
  output cto_pkg::entry_t         ent,
  output logic                    keep,
  output logic                    del_out
);
  import cto_pkg::*;

  entry_t ent_next;
  entry_t fresh;

  // compare against the broadcast key
  assign keep    = ent.valid && (ent.tstamp <= cmd.key_time);
  assign del_out = del_in || (ent.valid && (ent.sock == cmd.key_sock));

  assign fresh.valid  = 1'b1;
  assign fresh.tstamp = cmd.key_time;
  assign fresh.sock   = cmd.key_sock;

  // choose hold, new entry, or neighbor
  always_comb begin
    ent_next = ent;
    if (cmd.ins && !keep) begin
      ent_next = below_keep ? fresh : below;
    end
    if ((cmd.del && del_out) || cmd.pop) begin
      ent_next = above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/connection_timeout_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// connection_timeout_table: sorted connection timeout queue
// Keeps sockets ordered by expiry time in a chain of cells and reports
// every socket that is due when a tick arrives, and every insert dropped when full.
// ---------------------------------------------------------------------------
//   channel  role    fields
//   req      sink    op, socket_id, expiry, now_time
//   res      source  kind, out_socket, last
//
// Insert and delete finish in the cycle they are accepted. A tick first latches
// the time, then pops the expired sockets one after another off the head of
// the cell chain, or ends when nothing is due. The result register is a
// single stage, so a stalled result pauses popping and holds off new
// requests. Reset empties the table at once; there is no clearing pass.
// ---------------------------------------------------------------------------
module connection_timeout_table (
  input wire logic clk,
  input wire logic rst,
  cto_req_if.sink   req,
  cto_res_if.source res
);
  import cto_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  logic                 state;
  logic                 state_next;
  logic [TIME_BITS-1:0] now_reg;
  logic [SOCKETS-1:0]   present;

  logic                 out_v;
  logic                 out_kind;
  logic [SOCK_BITS-1:0] out_sock;
  logic                 out_last;

  entry_t               cells [SLOTS];
  logic                 keep  [SLOTS];
  logic                 dchain[SLOTS];
  logic [SLOTS-1:0]     valid_vec;
  cell_cmd_t            cmd;

  logic in_fire;
  logic out_free;
  logic full;
  logic is_present;
  logic drop;
  logic head_due;
  logic next_due;
  logic pop;

  assign out_free   = !out_v || res.ready;
  assign req.ready  = (state == ST_IDLE) && out_free;
  assign in_fire    = req.valid && req.ready;
  assign full       = cells[SLOTS-1].valid;
  assign is_present = present[req.socket_id];

  // decode the accepted request
  assign drop         = in_fire && (req.op == OP_INSERT) && !is_present && full;
  assign cmd.ins      = in_fire && (req.op == OP_INSERT) && !is_present && !full;
  assign cmd.del      = in_fire && (req.op == OP_DELETE) && is_present;
  assign cmd.pop      = pop;
  assign cmd.key_time = TIME_BITS'(req.expiry);
  assign cmd.key_sock = req.socket_id;

  // head of the chain against the latched tick time
  assign head_due = cells[0].valid && (cells[0].tstamp <= now_reg);
  assign next_due = cells[1].valid && (cells[1].tstamp <= now_reg);
  assign pop      = (state == ST_TICK) && head_due && out_free;

  // cell chain
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    entry_t below_e;
    entry_t above_e;
    logic   below_k;
    logic   del_i;

    if (i == 0) begin : g_bottom
      assign below_e = '0;
      assign below_k = 1'b1;
      assign del_i   = 1'b0;
    end else begin : g_inner
      assign below_e = cells[i-1];
      assign below_k = keep[i-1];
      assign del_i   = dchain[i-1];
    end

    if (i == SLOTS - 1) begin : g_top
      assign above_e = '0;
    end else begin : g_below_top
      assign above_e = cells[i+1];
    end

    cto_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .below      (below_e),
      .below_keep (below_k),
      .above      (above_e),
      .del_in     (del_i),
      .ent        (cells[i]),
      .keep       (keep[i]),
      .del_out    (dchain[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  // sequence ticks
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (req.op == OP_TICK)) begin
          state_next = ST_TICK;
        end
      end
      ST_TICK: begin
        if (!head_due || (pop && !next_due)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // latch the tick time
  always_ff @(posedge clk) begin
    if (in_fire && (req.op == OP_TICK)) begin
      now_reg <= TIME_BITS'(req.now_time);
    end
  end

  // track which sockets hold a cell
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else begin
      if (cmd.ins) begin
        present[req.socket_id] <= 1'b1;
      end
      if (cmd.del) begin
        present[req.socket_id] <= 1'b0;
      end
      if (pop) begin
        present[cells[0].sock] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (drop || pop) begin
      out_v <= 1'b1;
    end else if (res.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drop) begin
      out_kind <= KIND_DROPPED;
      out_sock <= req.socket_id;
      out_last <= 1'b1;
    end else if (pop) begin
      out_kind <= KIND_EXPIRED;
      out_sock <= cells[0].sock;
      out_last <= !next_due;
    end
  end

  assign res.valid      = out_v;
  assign res.kind       = out_kind;
  assign res.out_socket = out_sock;
  assign res.last       = out_last;

`ifndef SYNTHESIS
  // as many sockets are present as cells are valid
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(present) == $countones(valid_vec))
    else $error("present sockets and valid cells disagree");

  // valid cells stay packed at the low end
  a_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + SLOTS'(1))) == '0)
    else $error("valid cells not packed");

  // a dropped insert is only reported with the table full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_v && (out_kind == KIND_DROPPED)) |-> full)
    else $error("drop reported while table has room");

  // every pop loads an expired result
  a_pop_due: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_v && (out_kind == KIND_EXPIRED)))
    else $error("pop without expired result");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_connection_timeout_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_connection_timeout_table: testbench for the connection timeout table
// Drives insert, delete and tick requests with random gaps and compares every
// expired or dropped socket with a model of the sorted timeout chain.
// ---------------------------------------------------------------------------

typedef struct packed {
  logic                          kind;
  logic [cto_pkg::SOCK_BITS-1:0] sock;
  logic                          last;
} expiry_note_t;

// Tracks the timeout chain and the socket notes each request should produce.
class expiry_tracker;
  cto_pkg::entry_t chain[$];
  bit              sock_live[cto_pkg::SOCKETS];
  expiry_note_t    due_notes[$];
  int              errors;

  function new();
    errors = 0;
    foreach (sock_live[i]) sock_live[i] = 1'b0;
  endfunction

  // Apply one accepted request to the chain and queue the notes it causes.
  function void note_request(logic [cto_pkg::OP_BITS-1:0] op,
                             logic [cto_pkg::SOCK_BITS-1:0] sock,
                             logic [cto_pkg::FIELD_TIME-1:0] exp_t,
                             logic [cto_pkg::FIELD_TIME-1:0] now_t);
    cto_pkg::entry_t slot_ent;
    expiry_note_t    note;
    int              pos;
    int              popped;
    logic [cto_pkg::TIME_BITS-1:0] t_exp;
    logic [cto_pkg::TIME_BITS-1:0] t_now;
    t_exp = exp_t[cto_pkg::TIME_BITS-1:0];
    t_now = now_t[cto_pkg::TIME_BITS-1:0];
    case (op)
      cto_pkg::OP_INSERT: begin
        if (!sock_live[sock]) begin
          if (chain.size() >= cto_pkg::SLOTS) begin
            note.kind = cto_pkg::KIND_DROPPED;
            note.sock = sock;
            note.last = 1'b1;
            due_notes.push_back(note);
          end else begin
            // place after every cell with an equal or earlier expiry
            pos = 0;
            while (pos < chain.size() && chain[pos].tstamp <= t_exp) pos++;
            slot_ent.valid  = 1'b1;
            slot_ent.tstamp = t_exp;
            slot_ent.sock   = sock;
            chain.insert(pos, slot_ent);
            sock_live[sock] = 1'b1;
          end
        end
      end
      cto_pkg::OP_DELETE: begin
        if (sock_live[sock]) begin
          sock_live[sock] = 1'b0;
          for (int i = 0; i < chain.size(); i++) begin
            if (chain[i].sock == sock) begin
              chain.delete(i);
              break;
            end
          end
        end
      end
      cto_pkg::OP_TICK: begin
        // pop every due cell from the head, mark the final one
        popped = 0;
        while (chain.size() > 0 && chain[0].tstamp <= t_now) begin
          note.kind = cto_pkg::KIND_EXPIRED;
          note.sock = chain[0].sock;
          note.last = 1'b0;
          due_notes.push_back(note);
          sock_live[chain[0].sock] = 1'b0;
          void'(chain.pop_front());
          popped++;
        end
        if (popped > 0) due_notes[due_notes.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Compare one accepted note with the oldest one waiting.
  function void check_result(logic kind, logic [cto_pkg::SOCK_BITS-1:0] sock,
                             logic last);
    expiry_note_t want;
    if (due_notes.size() == 0) begin
      $error("unexpected result: kind %0d socket %0d last %0d", kind, sock, last);
      errors++;
      return;
    end
    want = due_notes.pop_front();
    if (kind !== want.kind) begin
      $error("kind mismatch: expected %0d actual %0d", want.kind, kind);
      errors++;
    end
    if (sock !== want.sock) begin
      $error("out_socket mismatch: expected %0d actual %0d", want.sock, sock);
      errors++;
    end
    if (last !== want.last) begin
      $error("last mismatch: expected %0d actual %0d", want.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return due_notes.size();
  endfunction
endclass

module tb_connection_timeout_table;
  import cto_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam logic [FIELD_TIME-1:0] T_MAX = 32'hFFFF_FFFF;

  logic clk;
  logic rst;

  cto_req_if req_ch ();
  cto_res_if res_ch ();

  connection_timeout_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  expiry_tracker tracker;

  bit send_gaps;
  bit recv_gaps;
  int hold_cycles;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop for a hung run
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // Offer one request, idling first at random, and hold it until accepted.
  task automatic send_request(logic [OP_BITS-1:0] op, logic [SOCK_BITS-1:0] sock,
                              logic [FIELD_TIME-1:0] exp_t,
                              logic [FIELD_TIME-1:0] now_t);
    while (send_gaps && $urandom_range(0, 99) < 37) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.socket_id <= sock;
    req_ch.expiry    <= exp_t;
    req_ch.now_time  <= now_t;
    do @(posedge clk); while (!req_ch.ready);
    tracker.note_request(op, sock, exp_t, now_t);
  endtask

  // Pick a random socket number.
  function automatic logic [SOCK_BITS-1:0] rand_sock();
    return SOCK_BITS'($urandom_range(0, SOCKETS - 1));
  endfunction

  // Pick a socket that is live in the chain, or any socket if none is.
  function automatic logic [SOCK_BITS-1:0] pick_live_sock();
    int live[$];
    foreach (tracker.sock_live[i]) if (tracker.sock_live[i]) live.push_back(i);
    if (live.size() == 0) return rand_sock();
    return SOCK_BITS'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic logic [FIELD_TIME-1:0] rand_time();
    if ($urandom_range(0, 99) < 15) return $urandom;
    return $urandom_range(0, 60);
  endfunction

  // One random request: mostly inserts and ticks over a narrow time window
  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 42)
      send_request(OP_INSERT, rand_sock(), rand_time(), $urandom);
    else if (r < 60)
      send_request(OP_DELETE,
                   ($urandom_range(0, 99) < 70) ? pick_live_sock() : rand_sock(),
                   $urandom, $urandom);
    else if (r < 94)
      send_request(OP_TICK, rand_sock(), $urandom, rand_time());
    else
      send_request(OP_UNUSED, rand_sock(), $urandom, $urandom);
  endtask

  // Fill the whole chain with every socket in shuffled order.
  task automatic fill_chain();
    int order[SOCKETS];
    int j;
    int tmp;
    foreach (order[i]) order[i] = i;
    for (int i = SOCKETS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i])
      send_request(OP_INSERT, SOCK_BITS'(order[i]), rand_time(), $urandom);
  endtask

  // Result side: sample at the rising edge, set ready at the falling edge.
  initial begin
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready)
        tracker.check_result(res_ch.kind, res_ch.out_socket, res_ch.last);
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_ch.ready <= recv_gaps ? ($urandom_range(0, 99) >= 37) : 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    tracker          = new();
    send_gaps        = 1'b1;
    recv_gaps        = 1'b1;
    hold_cycles      = 0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_INSERT;
    req_ch.socket_id = '0;
    req_ch.expiry    = '0;
    req_ch.now_time  = '0;
    res_ch.ready     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extreme fields, ties, duplicates, absent deletes, idle ticks
    send_request(OP_INSERT, 6'd0, 32'd0, 32'd0);
    send_request(OP_INSERT, 6'd63, T_MAX, T_MAX);
    send_request(OP_INSERT, 6'd0, 32'd5, 32'd0);
    send_request(OP_INSERT, 6'd21, 32'd10, 32'd0);
    send_request(OP_INSERT, 6'd42, 32'd10, 32'd0);
    send_request(OP_INSERT, 6'd7, 32'd10, 32'd0);
    send_request(OP_DELETE, 6'd42, 32'd0, 32'd0);
    send_request(OP_DELETE, 6'd42, T_MAX, T_MAX);
    send_request(OP_TICK, 6'd0, 32'd0, 32'd0);
    send_request(OP_TICK, 6'd0, T_MAX, 32'd0);
    send_request(OP_UNUSED, 6'd63, T_MAX, T_MAX);
    send_request(OP_TICK, 6'd0, 32'd0, 32'd10);
    send_request(OP_INSERT, 6'd5, 32'h8000_0000, 32'd0);
    send_request(OP_INSERT, 6'd9, 32'h7FFF_FFFF, 32'd0);
    send_request(OP_INSERT, 6'd42, 32'h7FFF_FFFF, 32'd0);
    send_request(OP_TICK, 6'd0, 32'd0, 32'hFFFF_FFFE);
    send_request(OP_TICK, 6'd0, 32'd0, T_MAX);
    send_request(OP_TICK, 6'd0, 32'd0, T_MAX);
    send_request(OP_DELETE, 6'd63, 32'd0, 32'd0);

    // random traffic with gaps on both sides
    repeat (120) send_random();

    // full chain with no gaps, then pop all of it into a stalled receiver
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    fill_chain();
    repeat (5) send_request(OP_INSERT, rand_sock(), rand_time(), 32'd0);
    hold_cycles = 400;
    send_request(OP_TICK, 6'd0, 32'd0, T_MAX);
    repeat (30) send_random();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;

    repeat (140) send_random();

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // drain outstanding results, then allow the pipeline to settle
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (tracker.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
